>>> hw/rtl/msq_pkg.sv
// Shared types, constants and helper functions for the marching squares cell unit.
// Used by msq_front, msq_queue, msq_back and marching_squares_cell.
`default_nettype none
package msq_pkg;

	localparam int GRID_SIZE = 256;
	localparam int DIV_STEPS = 16;
	localparam int LANES     = 2;
	localparam int QDEPTH    = 4;

	localparam logic [31:0] THRESHOLD_RST   = 32'd41943;
	localparam logic [15:0] PIXEL_SCALE_RST = 16'd1707;

	typedef enum logic {
		REG_THRESHOLD   = 1'b0,
		REG_PIXEL_SCALE = 1'b1
	} msq_reg_t;

	typedef struct packed {
		logic [7:0]  cell_x;
		logic [7:0]  cell_y;
		logic [31:0] value_00;
		logic [31:0] value_10;
		logic [31:0] value_01;
		logic [31:0] value_11;
		logic [31:0] value_center;
	} msq_in_t;

	typedef struct packed {
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] end_x;
		logic [15:0] end_y;
		logic        last_segment;
	} msq_out_t;

	// One edge crossing: fixed axis grid position, moving axis grid position,
	// direction of travel from the inside corner, and the interpolation ratio.
	typedef struct packed {
		logic [8:0]  fix_base;
		logic [8:0]  move_base;
		logic        axis_x;
		logic        neg;
		logic [31:0] num;
		logic [31:0] den;
	} msq_xing_t;

	typedef struct packed {
		msq_xing_t a;
		msq_xing_t b;
		logic      last;
	} msq_job_t;

	typedef logic [2:0] msq_cand_t;

	typedef struct packed {
		logic [2:0]      cnt;
		msq_cand_t [3:0] code;
	} msq_slots_t;

	typedef struct packed {
		logic [31:0] rem;
		logic        q;
	} msq_dstep_t;

	// Candidate crossings in visiting order: corner and the neighbor it faces.
	localparam logic [1:0] CAND_IN  [8] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3};
	localparam logic [1:0] CAND_OUT [8] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd3, 2'd2, 2'd1};

	function automatic msq_slots_t xing_slots(input logic [3:0] mask);
		msq_slots_t s;
		s = '0;
		for (int c = 0; c < 8; c++) begin
			if (mask[CAND_IN[c]] && !mask[CAND_OUT[c]] && s.cnt < 3'd4) begin
				s.code[s.cnt[1:0]] = c[2:0];
				s.cnt = s.cnt + 3'd1;
			end
		end
		return s;
	endfunction

	function automatic logic [15:0] sat16(input logic [21:0] v);
		return (|v[21:16]) ? 16'hFFFF : v[15:0];
	endfunction

	// One restoring division step: shift in a dividend bit, subtract if it fits.
	function automatic msq_dstep_t div_step(input logic [31:0] rem, input logic nbit,
			input logic [31:0] den);
		msq_dstep_t r;
		logic [32:0] t;
		t = {rem, nbit};
		if (t >= {1'b0, den}) begin
			r.q   = 1'b1;
			r.rem = 32'(t - {1'b0, den});
		end else begin
			r.q   = 1'b0;
			r.rem = t[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/marching_squares_cell.sv
// Path of a cell: front end, queue, multiply stage, divider stages, output register.
// Throughput: one segment per cycle unless stalled; a saddle cell yields two front end jobs.
// The rate is set by the single segment slot of the 16-stage, two-lane divider pipeline.
// Reset clears all valid bits and the queue and loads the register reset values.
// Top level of the marching squares cell unit: config registers, front, queue, back.
// Depends on msq_pkg, msq_front, msq_queue, msq_back.
`default_nettype none
module marching_squares_cell import msq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire msq_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output msq_out_t         out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [31:0] threshold_q;
	logic [15:0] pixel_scale_q;
	msq_reg_t    reg_sel;
	logic        f_valid, f_ready;
	msq_job_t    f_job;
	logic        q_valid, q_ready;
	msq_job_t    q_job;

	assign pready  = 1'b1;
	assign reg_sel = msq_reg_t'(paddr[2]);

	always_comb begin
		case (reg_sel)
			REG_THRESHOLD:   prdata = threshold_q;
			REG_PIXEL_SCALE: prdata = {16'd0, pixel_scale_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= THRESHOLD_RST;
			pixel_scale_q <= PIXEL_SCALE_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_THRESHOLD:   threshold_q   <= pwdata;
				REG_PIXEL_SCALE: pixel_scale_q <= pwdata[15:0];
				default:         ;
			endcase
		end
	end

	msq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.threshold (threshold_q),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	msq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_job    (q_job)
	);

	msq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (q_valid),
		.job_ready   (q_ready),
		.job         (q_job),
		.pixel_scale (pixel_scale_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

`ifndef SYNTHESIS
	// a job waiting at the queue head survives a stalled back end
	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !q_ready) |=> q_valid)
		else $error("queue head lost while back end stalled");

	// back end only stalls when a finished segment is waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!q_ready |-> (out_valid && !out_ready))
		else $error("back end stalled without a pending output");

	// a stalled front end job does not change its last flag
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && !f_ready && !(in_valid && in_ready)) |=> $stable(f_job.last))
		else $error("front end job changed while stalled");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/msq_front.sv
// Front end: holds one cell, classifies its corners and issues segment jobs.
// Depends on msq_pkg.
`default_nettype none
module msq_front import msq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire msq_in_t     in_data,
	input  wire logic [31:0] threshold,
	output logic             job_valid,
	input  wire logic        job_ready,
	output msq_job_t         job
);

	msq_in_t    cell_q;
	logic       busy_q;
	logic       phase_q;
	logic [3:0] mask;
	logic [31:0] num0, num1, num2, num3;
	logic [31:0] den_e0, den_e1, den_e2, den_e3;
	msq_slots_t sl;
	logic [1:0] nseg;
	logic       offgrid;
	msq_cand_t  ca, cb;
	logic       last_job;
	logic       push;
	logic       done;

	function automatic msq_xing_t xing_of(input msq_cand_t code);
		msq_xing_t x;
		logic [1:0] ci, co;
		logic [8:0] bx, by;
		ci = CAND_IN[code];
		co = CAND_OUT[code];
		bx = {1'b0, cell_q.cell_x} + {8'd0, ci[0]};
		by = {1'b0, cell_q.cell_y} + {8'd0, ci[1]};
		x.axis_x = (ci[1] == co[1]);
		if (x.axis_x) begin
			x.move_base = bx;
			x.fix_base  = by;
			x.neg       = co[0] < ci[0];
		end else begin
			x.move_base = by;
			x.fix_base  = bx;
			x.neg       = co[1] < ci[1];
		end
		case (ci)
			2'd0:    x.num = num0;
			2'd1:    x.num = num1;
			2'd2:    x.num = num2;
			default: x.num = num3;
		endcase
		case (code)
			3'd0, 3'd3: x.den = den_e0;
			3'd1, 3'd4: x.den = den_e1;
			3'd2, 3'd7: x.den = den_e2;
			default:    x.den = den_e3;
		endcase
		return x;
	endfunction

	always_comb begin
		mask[0] = cell_q.value_00 > threshold;
		mask[1] = cell_q.value_10 > threshold;
		mask[2] = cell_q.value_01 > threshold;
		mask[3] = cell_q.value_11 > threshold;
		num0 = cell_q.value_00 - threshold;
		num1 = cell_q.value_10 - threshold;
		num2 = cell_q.value_01 - threshold;
		num3 = cell_q.value_11 - threshold;
		den_e0 = mask[0] ? cell_q.value_00 - cell_q.value_10 : cell_q.value_10 - cell_q.value_00;
		den_e1 = mask[0] ? cell_q.value_00 - cell_q.value_01 : cell_q.value_01 - cell_q.value_00;
		den_e2 = mask[1] ? cell_q.value_10 - cell_q.value_11 : cell_q.value_11 - cell_q.value_10;
		den_e3 = mask[2] ? cell_q.value_01 - cell_q.value_11 : cell_q.value_11 - cell_q.value_01;
		sl = xing_slots(mask);
		offgrid = ({24'd0, cell_q.cell_x} >= 32'(GRID_SIZE - 1))
			|| ({24'd0, cell_q.cell_y} >= 32'(GRID_SIZE - 1));
		if (offgrid)
			nseg = 2'd0;
		else if (sl.cnt == 3'd2)
			nseg = 2'd1;
		else if (sl.cnt == 3'd4)
			nseg = 2'd2;
		else
			nseg = 2'd0;
		// saddle pairing follows the center value
		if (nseg == 2'd1) begin
			ca = sl.code[0];
			cb = sl.code[1];
			last_job = 1'b1;
		end else if (cell_q.value_center > threshold) begin
			ca = phase_q ? sl.code[0] : sl.code[1];
			cb = phase_q ? sl.code[3] : sl.code[2];
			last_job = phase_q;
		end else begin
			ca = phase_q ? sl.code[2] : sl.code[0];
			cb = phase_q ? sl.code[3] : sl.code[1];
			last_job = phase_q;
		end
		job.a    = xing_of(ca);
		job.b    = xing_of(cb);
		job.last = last_job;
		job_valid = busy_q && (nseg != 2'd0);
		push      = job_valid && job_ready;
		done      = busy_q && ((nseg == 2'd0) || (push && last_job));
		in_ready  = !busy_q || done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (done) begin
			busy_q  <= 1'b0;
		end else if (push) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cell_q <= in_data;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/msq_queue.sv
// Short job queue between the front end and the divider pipeline.
// Depends on msq_pkg.
`default_nettype none
module msq_queue import msq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire msq_job_t push_job,
	output logic          pop_valid,
	input  wire logic     pop_ready,
	output msq_job_t      pop_job
);

	localparam int PW = $clog2(QDEPTH);

	msq_job_t        mem_q [QDEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;
	logic            do_push, do_pop;

	always_comb begin
		push_ready = cnt_q != (PW+1)'(QDEPTH);
		pop_valid  = cnt_q != '0;
		pop_job    = mem_q[rd_q];
		do_push    = push_valid && push_ready;
		do_pop     = pop_valid && pop_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + PW'(1);
			if (do_pop)
				rd_q <= rd_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (PW+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/msq_back.sv
// Back end: scales crossings to pixels through a pipelined divider, two lanes.
// Depends on msq_pkg.
`default_nettype none
module msq_back import msq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        job_valid,
	output logic             job_ready,
	input  wire msq_job_t    job,
	input  wire logic [15:0] pixel_scale,
	output logic             out_valid,
	input  wire logic        out_ready,
	output msq_out_t         out_data
);

	logic adv;

	// multiply stage
	logic        vld_s1;
	logic        last_s1;
	logic [47:0] prod_s1  [LANES];
	logic [31:0] den_s1   [LANES];
	logic [24:0] kmove_s1 [LANES];
	logic [15:0] pfix_s1  [LANES];
	logic        axis_s1  [LANES];
	logic        neg_s1   [LANES];

	// divider stages, one quotient bit each
	logic        vld_s2   [DIV_STEPS];
	logic        last_s2  [DIV_STEPS];
	logic [31:0] rem_s2   [LANES][DIV_STEPS];
	logic [15:0] lo_s2    [LANES][DIV_STEPS];
	logic [15:0] quo_s2   [LANES][DIV_STEPS];
	logic [31:0] den_s2   [LANES][DIV_STEPS];
	logic [24:0] kmove_s2 [LANES][DIV_STEPS];
	logic [15:0] pfix_s2  [LANES][DIV_STEPS];
	logic        axis_s2  [LANES][DIV_STEPS];
	logic        neg_s2   [LANES][DIV_STEPS];

	msq_dstep_t  st       [LANES][DIV_STEPS];
	logic [15:0] lo_in    [LANES][DIV_STEPS];
	logic [15:0] quo_in   [LANES][DIV_STEPS];

	logic        out_valid_q;
	msq_out_t    out_q;
	logic [15:0] pmove    [LANES];
	logic [15:0] px       [LANES];
	logic [15:0] py       [LANES];

	msq_xing_t   xin      [LANES];

	assign adv       = !out_valid_q || out_ready;
	assign job_ready = adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		xin[0] = job.a;
		xin[1] = job.b;
		for (int l = 0; l < LANES; l++) begin
			for (int s = 0; s < DIV_STEPS; s++) begin
				if (s == 0) begin
					st[l][s]     = div_step(prod_s1[l][47:16], prod_s1[l][15], den_s1[l]);
					lo_in[l][s]  = {prod_s1[l][14:0], 1'b0};
					quo_in[l][s] = 16'd0;
				end else begin
					st[l][s]     = div_step(rem_s2[l][s-1], lo_s2[l][s-1][15],
						den_s2[l][s-1]);
					lo_in[l][s]  = {lo_s2[l][s-1][14:0], 1'b0};
					quo_in[l][s] = quo_s2[l][s-1];
				end
			end
		end
	end

	// final correction: floor the offset from the inside corner either way, then round and saturate
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [25:0] c;
			logic [15:0] q;
			logic        rnz;
			q   = quo_s2[l][DIV_STEPS-1];
			rnz = |rem_s2[l][DIV_STEPS-1];
			if (neg_s2[l][DIV_STEPS-1])
				c = {1'b0, kmove_s2[l][DIV_STEPS-1]} - {10'd0, q} - {25'd0, rnz};
			else
				c = {1'b0, kmove_s2[l][DIV_STEPS-1]} + {10'd0, q};
			pmove[l] = sat16(c[25:4]);
			if (axis_s2[l][DIV_STEPS-1]) begin
				px[l] = pmove[l];
				py[l] = pfix_s2[l][DIV_STEPS-1];
			end else begin
				px[l] = pfix_s2[l][DIV_STEPS-1];
				py[l] = pmove[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < DIV_STEPS; s++)
				vld_s2[s] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= job_valid;
			for (int s = 0; s < DIV_STEPS; s++)
				vld_s2[s] <= (s == 0) ? vld_s1 : vld_s2[s-1];
			out_valid_q <= vld_s2[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= job.last;
			for (int l = 0; l < LANES; l++) begin
				logic [24:0] kf;
				kf = {16'd0, xin[l].fix_base} * {9'd0, pixel_scale} + 25'd8;
				prod_s1[l]  <= {16'd0, xin[l].num} * {32'd0, pixel_scale};
				den_s1[l]   <= xin[l].den;
				kmove_s1[l] <= {16'd0, xin[l].move_base} * {9'd0, pixel_scale} + 25'd8;
				pfix_s1[l]  <= sat16({1'b0, kf[24:4]});
				axis_s1[l]  <= xin[l].axis_x;
				neg_s1[l]   <= xin[l].neg;
			end
			for (int s = 0; s < DIV_STEPS; s++) begin
				last_s2[s] <= (s == 0) ? last_s1 : last_s2[s-1];
				for (int l = 0; l < LANES; l++) begin
					rem_s2[l][s] <= st[l][s].rem;
					lo_s2[l][s]  <= lo_in[l][s];
					quo_s2[l][s] <= {quo_in[l][s][14:0], st[l][s].q};
					if (s == 0) begin
						den_s2[l][s]   <= den_s1[l];
						kmove_s2[l][s] <= kmove_s1[l];
						pfix_s2[l][s]  <= pfix_s1[l];
						axis_s2[l][s]  <= axis_s1[l];
						neg_s2[l][s]   <= neg_s1[l];
					end else begin
						den_s2[l][s]   <= den_s2[l][s-1];
						kmove_s2[l][s] <= kmove_s2[l][s-1];
						pfix_s2[l][s]  <= pfix_s2[l][s-1];
						axis_s2[l][s]  <= axis_s2[l][s-1];
						neg_s2[l][s]   <= neg_s2[l][s-1];
					end
				end
			end
			out_q.start_x      <= px[0];
			out_q.start_y      <= py[0];
			out_q.end_x        <= px[1];
			out_q.end_y        <= py[1];
			out_q.last_segment <= last_s2[DIV_STEPS-1];
		end
	end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for marching_squares_cell: random and directed cells, APB setup.
// Depends on msq_pkg and the marching_squares_cell RTL.
`default_nettype none
module tb_top import msq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	msq_in_t in_data;
	msq_out_t out_data;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	marching_squares_cell uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [31:0] iso_level;
	logic [15:0] px_scale;
	msq_out_t segments_due[$];
	int errors;
	int idle_cycles;
	bit hold_off;
	bit rx_random;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Grid position times pixel scale, rounded to Q12.4 and saturated.
	function automatic logic [15:0] grid_to_px(logic [8:0] base, int dir,
			logic [63:0] num, logic [63:0] den);
		logic [127:0] n;
		logic [127:0] p;
		n = base * den;
		if (dir > 0) n = n + num;
		else if (dir < 0) n = n - num;
		p = (n * px_scale + den * 8) / (den * 16);
		return (p > 65535) ? 16'hFFFF : p[15:0];
	endfunction

	function automatic void edge_point(logic [7:0] cx, logic [7:0] cy,
			logic [31:0] v[4], int ci, int co, output logic [15:0] px,
			output logic [15:0] py);
		logic [63:0] num, den;
		int ix, iy, ox, oy;
		num = {32'd0, v[ci]} - {32'd0, iso_level};
		den = {32'd0, v[ci]} - {32'd0, v[co]};
		ix = ci & 1; iy = ci >> 1; ox = co & 1; oy = co >> 1;
		if (den == 0) den = 1;
		if (num > den) num = den;
		px = grid_to_px({1'b0, cx} + 9'(ix), ox - ix, num, den);
		py = grid_to_px({1'b0, cy} + 9'(iy), oy - iy, num, den);
	endfunction

	function automatic void predict_segments(msq_in_t c);
		int first_nb[4] = '{1, 3, 0, 2};
		int second_nb[4] = '{2, 0, 3, 1};
		logic [31:0] v[4];
		logic [15:0] ptx[4], pty[4];
		msq_out_t s;
		int n;
		v[0] = c.value_00; v[1] = c.value_10; v[2] = c.value_01; v[3] = c.value_11;
		n = 0;
		if (c.cell_x >= GRID_SIZE - 1 || c.cell_y >= GRID_SIZE - 1) return;
		for (int k = 0; k < 4; k++) begin
			if (v[k] <= iso_level) continue;
			if (v[first_nb[k]] <= iso_level && n < 4) begin
				edge_point(c.cell_x, c.cell_y, v, k, first_nb[k], ptx[n], pty[n]);
				n++;
			end
			if (v[second_nb[k]] <= iso_level && n < 4) begin
				edge_point(c.cell_x, c.cell_y, v, k, second_nb[k], ptx[n], pty[n]);
				n++;
			end
		end
		if (n == 2) begin
			s = '{ptx[0], pty[0], ptx[1], pty[1], 1'b1};
			segments_due.push_back(s);
		end else if (n == 4) begin
			if (c.value_center > iso_level) begin
				s = '{ptx[1], pty[1], ptx[2], pty[2], 1'b0};
				segments_due.push_back(s);
				s = '{ptx[0], pty[0], ptx[3], pty[3], 1'b1};
				segments_due.push_back(s);
			end else begin
				s = '{ptx[0], pty[0], ptx[1], pty[1], 1'b0};
				segments_due.push_back(s);
				s = '{ptx[2], pty[2], ptx[3], pty[3], 1'b1};
				segments_due.push_back(s);
			end
		end
	endfunction

	// Receiver: random stalls, or a long hold when asked.
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (out_ready && !(out_valid)) begin
				out_ready <= 1'b1;
			end else begin
				gap = rx_random ? $urandom_range(0, 6) : 0;
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				out_ready <= 1'b1;
			end
		end
	end

	// Check every accepted segment against the oldest prediction.
	always @(posedge clk) begin
		msq_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (segments_due.size() == 0) begin
				$display("%0t: unexpected segment %h", $time, out_data);
				errors++;
			end else begin
				want = segments_due.pop_front();
				if (want.start_x !== out_data.start_x || want.start_y !== out_data.start_y
						|| want.end_x !== out_data.end_x || want.end_y !== out_data.end_y
						|| want.last_segment !== out_data.last_segment) begin
					$display("%0t: segment mismatch expected %h actual %h", $time,
						want, out_data);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Keep valid up between items with no gap; drop it only while waiting.
	task automatic send_cell(msq_in_t c, int max_gap);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= c;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_segments(c);
		@(negedge clk);
	endtask

	task automatic write_reg(msq_reg_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(idx) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_THRESHOLD) iso_level = val;
		else px_scale = val[15:0];
	endtask

	task automatic wait_idle();
		while (segments_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return iso_level;
			3: return iso_level + 1;
			default: return $urandom();
		endcase
	endfunction

	function automatic msq_in_t random_cell();
		msq_in_t c;
		c.cell_x = ($urandom_range(0, 15) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 254));
		c.cell_y = ($urandom_range(0, 15) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 254));
		c.value_00 = pick_value();
		c.value_10 = pick_value();
		c.value_01 = pick_value();
		c.value_11 = pick_value();
		c.value_center = pick_value();
		return c;
	endfunction

	task automatic test_directed();
		msq_in_t c;
		logic [31:0] hi, lo;
		hi = 32'hFFFF_FFFF; lo = 32'd0;
		for (int m = 0; m < 16; m++) begin
			c.cell_x = (m == 5) ? 8'd254 : 8'($urandom());
			c.cell_y = (m == 6) ? 8'd254 : 8'($urandom_range(0, 254));
			c.value_00 = m[0] ? hi : lo;
			c.value_10 = m[1] ? hi : lo;
			c.value_01 = m[2] ? hi : lo;
			c.value_11 = m[3] ? hi : lo;
			c.value_center = m[4] ? hi : lo;
			send_cell(c, 2);
		end
		// saddles with center above and not above threshold, cells off the grid, and a near-threshold cell
		c = '{8'd3, 8'd4, hi, lo, lo, hi, hi};
		send_cell(c, 0);
		c.value_center = iso_level;
		send_cell(c, 0);
		c = '{8'd10, 8'd20, lo, iso_level + 1, iso_level + 1, lo, lo};
		send_cell(c, 0);
		c = '{8'd255, 8'd0, hi, lo, lo, lo, lo};
		send_cell(c, 0);
		c = '{8'd0, 8'd255, hi, lo, lo, lo, lo};
		send_cell(c, 0);
		c = '{8'd0, 8'd0, iso_level + 1, iso_level, iso_level, iso_level, lo};
		send_cell(c, 0);
		in_valid <= 1'b0;
		wait_idle();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_cell(random_cell(), ($urandom_range(0, 3) == 0) ? 0 : 6);
		in_valid <= 1'b0;
		wait_idle();
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				for (int i = 0; i < 40; i++) send_cell(random_cell(), 0);
				in_valid <= 1'b0;
			end
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		wait_idle();
	endtask

	initial begin
		errors = 0; idle_cycles = 0; hold_off = 1'b0; rx_random = 1'b0;
		iso_level = THRESHOLD_RST; px_scale = PIXEL_SCALE_RST;
		in_valid = 1'b0; in_data = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		rx_random = 1'b1;
		test_random(350);
		write_reg(REG_THRESHOLD, 32'd0);
		write_reg(REG_PIXEL_SCALE, 16'hFFFF);
		test_directed();
		test_random(350);
		write_reg(REG_THRESHOLD, 32'hFFFF_FFFE);
		write_reg(REG_PIXEL_SCALE, 16'd1);
		test_random(300);
		write_reg(REG_THRESHOLD, 32'h0100_0000);
		write_reg(REG_PIXEL_SCALE, 16'h1000);
		test_backpressure();
		test_random(350);
		write_reg(REG_THRESHOLD, $urandom());
		write_reg(REG_PIXEL_SCALE, 16'($urandom_range(1, 65535)));
		test_random(350);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
